/* src/lrast_pkg.sv */
package lrast_pkg;

    // Coordinate and field widths.
    localparam int COORD_BITS = 10;
    localparam int CFG_BITS   = 11;
    localparam int COLOR_BITS = 16;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int CMP_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

    // Input beat layout: x_start, y_start, x_end, y_end, pen_color from bit 0 up.
    localparam int IN_XS_LSB       = 0;
    localparam int IN_YS_LSB       = IN_XS_LSB + COORD_BITS;
    localparam int IN_XE_LSB       = IN_YS_LSB + COORD_BITS;
    localparam int IN_YE_LSB       = IN_XE_LSB + COORD_BITS;
    localparam int IN_COLOR_LSB    = IN_YE_LSB + COORD_BITS;
    localparam int IN_FIELDS_BITS  = IN_COLOR_LSB + COLOR_BITS;
    localparam int IN_TDATA_BITS   = ((IN_FIELDS_BITS + 7) / 8) * 8;

    // Output beat layout: pixel_x, pixel_y, pixel_color from bit 0 up.
    localparam int OUT_FIELDS_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELDS_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS  = 2;

    // Configuration register indexes.
    localparam int REG_IDX_BITS = 1;
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_idx_t;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(240);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(320);

    // Opcodes carried on the input tuser.
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    // One result beat.
    typedef struct packed {
        logic [COLOR_BITS-1:0] color;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic                  valid;
        logic                  on_screen;
        logic                  last;
    } pixel_t;

endpackage

/* src/line_rasterizer_core.sv */
// Bresenham line engine. A start beat (tuser = start) loads two endpoints and a
// color and returns nothing; each step beat then returns one pixel with its color,
// an on-screen flag against the configured width and height, and tlast on the final
// pixel. A step beat with no line running returns one beat with every field zero.
// The engine takes one beat per clock while the skid entry is empty: each step is a single
// add and compare on the line state registers. Its result is registered into the output register,
// or into the skid entry of the two-entry stage while the output side is stalled, which lets
// the input keep flowing for one beat. The user must write width and height through the
// configuration port only while no line work is pending; the block itself does not enforce this.
module line_rasterizer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [lrast_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [lrast_pkg::CFG_BITS-1:0]       cfg_data,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: x_start, y_start, x_end, y_end, pen_color.
    input  logic [lrast_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic                                 s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: pixel_x, pixel_y, pixel_color, zero fill.
    output logic [lrast_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: pixel_valid, on_screen.
    output logic [lrast_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,
    output logic                                 m_axis_tlast
);
    import lrast_pkg::*;

    // Configuration registers.
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;

    // Line state.
    logic                  active_reg,    active_next;
    logic                  steep_reg,     steep_next;
    logic                  down_reg,      down_next;
    logic [COORD_BITS-1:0] major_reg,     major_next;
    logic [COORD_BITS-1:0] minor_reg,     minor_next;
    logic [COORD_BITS-1:0] major_end_reg, major_end_next;
    logic [COORD_BITS-1:0] dmaj_reg,      dmaj_next;
    logic [COORD_BITS-1:0] dmin_reg,      dmin_next;
    logic [ERR_BITS-1:0]   err_reg,       err_next;
    logic [COLOR_BITS-1:0] color_reg,     color_next;

    // Output stage.
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    pixel_t out_reg, out_next;
    pixel_t skid_reg, skid_next;

    logic    in_fire;
    logic    is_start;
    logic    produce;
    pixel_t  result;

    // Start decode.
    logic [COORD_BITS-1:0] xa, ya, xb, yb;
    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep_in;
    logic [COORD_BITS-1:0] ma, na, mb, nb;
    logic                  flip;
    logic [COORD_BITS-1:0] p0m, p0n, p1m, p1n;

    // Step decode.
    logic [COORD_BITS-1:0] px, py;
    logic                  fin;
    logic [ERR_BITS-1:0]   err_sub;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_start      = (opcode_t'(s_axis_tuser) == OP_START);
    assign produce       = in_fire && !is_start;

    // Endpoint unpacking, axis swap and ordering along the major axis.
    always_comb
    begin
        xa  = s_axis_tdata[IN_XS_LSB +: COORD_BITS];
        ya  = s_axis_tdata[IN_YS_LSB +: COORD_BITS];
        xb  = s_axis_tdata[IN_XE_LSB +: COORD_BITS];
        yb  = s_axis_tdata[IN_YE_LSB +: COORD_BITS];
        adx = (xa > xb) ? (xa - xb) : (xb - xa);
        ady = (ya > yb) ? (ya - yb) : (yb - ya);
        steep_in = ady > adx;
        ma  = steep_in ? ya : xa;
        na  = steep_in ? xa : ya;
        mb  = steep_in ? yb : xb;
        nb  = steep_in ? xb : yb;
        flip = ma > mb;
        p0m = flip ? mb : ma;
        p0n = flip ? nb : na;
        p1m = flip ? ma : mb;
        p1n = flip ? na : nb;
    end

    // Current pixel and its classification.
    always_comb
    begin
        px  = steep_reg ? minor_reg : major_reg;
        py  = steep_reg ? major_reg : minor_reg;
        fin = major_reg >= major_end_reg;
        err_sub = err_reg - {1'b0, dmin_reg};

        result = '0;
        if (active_reg)
        begin
            result.x         = px;
            result.y         = py;
            result.color     = color_reg;
            result.valid     = 1'b1;
            result.on_screen = (CMP_BITS'(px) < CMP_BITS'(width_reg)) &&
                               (CMP_BITS'(py) < CMP_BITS'(height_reg));
            result.last      = fin;
        end
    end

    // Line state update for start and step beats.
    always_comb
    begin
        active_next    = active_reg;
        steep_next     = steep_reg;
        down_next      = down_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        major_end_next = major_end_reg;
        dmaj_next      = dmaj_reg;
        dmin_next      = dmin_reg;
        err_next       = err_reg;
        color_next     = color_reg;

        if (in_fire && is_start)
        begin
            active_next    = 1'b1;
            steep_next     = steep_in;
            down_next      = p0n > p1n;
            major_next     = p0m;
            minor_next     = p0n;
            major_end_next = p1m;
            dmaj_next      = p1m - p0m;
            dmin_next      = (p0n > p1n) ? (p0n - p1n) : (p1n - p0n);
            err_next       = {2'b00, dmaj_next[COORD_BITS-1:1]};
            color_next     = s_axis_tdata[IN_COLOR_LSB +: COLOR_BITS];
        end
        else if (produce && active_reg)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_next = major_reg + 1'b1;
                if (err_sub[ERR_BITS-1])
                begin
                    minor_next = down_reg ? (minor_reg - 1'b1) : (minor_reg + 1'b1);
                    err_next   = err_sub + {1'b0, dmaj_reg};
                end
                else
                begin
                    err_next = err_sub;
                end
            end
        end
    end

    // Two-entry output stage.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_next  = skid_valid_reg || produce;
            out_next        = skid_valid_reg ? skid_reg : result;
            skid_valid_next = 1'b0;
        end
        else if (produce)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // Control and line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            steep_reg      <= 1'b0;
            down_reg       <= 1'b0;
            major_reg      <= '0;
            minor_reg      <= '0;
            major_end_reg  <= '0;
            dmaj_reg       <= '0;
            dmin_reg       <= '0;
            err_reg        <= '0;
            color_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            steep_reg      <= steep_next;
            down_reg       <= down_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
            major_end_reg  <= major_end_next;
            dmaj_reg       <= dmaj_next;
            dmin_reg       <= dmin_next;
            err_reg        <= err_next;
            color_reg      <= color_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'({out_reg.color, out_reg.y, out_reg.x});
    assign m_axis_tuser  = {out_reg.on_screen, out_reg.valid};
    assign m_axis_tlast  = out_reg.last;

    // The skid entry is only ever filled behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    // A step on the final pixel ends the line.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && active_reg && fin) |=> !active_reg)
        else $error("line still active after its final pixel");

    // The error term never goes negative between steps.
    a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !err_reg[ERR_BITS-1])
        else $error("error term negative while drawing");

    // The major coordinate never passes the line end.
    a_major_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (major_reg <= major_end_reg))
        else $error("major coordinate beyond line end");

endmodule

/* verif/line_rasterizer_core_test.sv */
module line_rasterizer_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lrast_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BEATS  = 305;
    localparam int NUM_ROWS      = 23;
    localparam int NUM_PHASES    = 6;

    localparam pixel_t NO_PIXEL = '0;

    // One row of the directed table; a typed pixel replaces the predicted one.
    typedef struct {
        opcode_t               op;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [COLOR_BITS-1:0] color;
        bit                    typed;
        pixel_t                want;
    } stim_row_t;

    // One screen setting and whether both sides run without idling.
    typedef struct {
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
        bit                  calm;
    } screen_cfg_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [REG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
    logic                      m_axis_tlast;

    // Line state of the predictor.
    logic [COORD_BITS-1:0]      ln_major;
    logic [COORD_BITS-1:0]      ln_minor;
    logic [COORD_BITS-1:0]      ln_major_end;
    logic [COORD_BITS-1:0]      ln_dmajor;
    logic [COORD_BITS-1:0]      ln_dminor;
    logic signed [ERR_BITS-1:0] ln_err;
    logic                       ln_down;
    logic                       ln_steep;
    logic                       ln_busy;
    logic [COLOR_BITS-1:0]      ln_color;
    logic [CFG_BITS-1:0]        scr_w;
    logic [CFG_BITS-1:0]        scr_h;

    pixel_t pending_pixels[$];
    bit     steady_mode = 1'b0;
    int     mismatch_count = 0;
    int     beats_sent = 0;
    int     lines_started = 0;
    int     pixels_checked = 0;
    int     offscreen_pixels = 0;
    int     idle_replies = 0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, NO_PIXEL},
        '{OP_START, 10'd5,    10'd7,    10'd5,    10'd7,    16'hFFFF, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1,
          pixel_t'{16'hFFFF, 10'd7, 10'd5, 1'b1, 1'b1, 1'b1}},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, NO_PIXEL},
        '{OP_START, 10'd0,    10'd0,    10'd1023, 10'd1023, 16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1,
          pixel_t'{16'h0000, 10'd0, 10'd0, 1'b1, 1'b1, 1'b0}},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_START, 10'd1023, 10'd0,    10'd0,    10'd1023, 16'hAAAA, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1,
          pixel_t'{16'hAAAA, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b0}},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_START, 10'd10,   10'd1000, 10'd12,   10'd3,    16'h5555, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_START, 10'd296,  10'd20,   10'd290,  10'd22,   16'h1234, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, NO_PIXEL},
        '{OP_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, NO_PIXEL}
    };

    screen_cfg_t screen_phases [NUM_PHASES] = '{
        '{11'd1024, 11'd1024, 1'b0},
        '{11'd0,    11'd0,    1'b0},
        '{11'd2047, 11'd1,    1'b1},
        '{11'd1,    11'd2047, 1'b0},
        '{11'd240,  11'd320,  1'b0},
        '{11'd511,  11'd700,  1'b0}
    };

    line_rasterizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [COORD_BITS-1:0] coord_dist(logic [COORD_BITS-1:0] a,
                                                         logic [COORD_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Latch a new line: swap axes when steep, then order along the major axis.
    function automatic void load_line(logic [COORD_BITS-1:0] xa, logic [COORD_BITS-1:0] ya,
                                      logic [COORD_BITS-1:0] xb, logic [COORD_BITS-1:0] yb,
                                      logic [COLOR_BITS-1:0] color);
        logic [COORD_BITS-1:0] t;
        ln_steep = coord_dist(ya, yb) > coord_dist(xa, xb);
        if (ln_steep)
        begin
            t = xa; xa = ya; ya = t;
            t = xb; xb = yb; yb = t;
        end
        if (xa > xb)
        begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        ln_major     = xa;
        ln_minor     = ya;
        ln_major_end = xb;
        ln_dmajor    = xb - xa;
        ln_dminor    = coord_dist(ya, yb);
        ln_down      = ya > yb;
        ln_err       = $signed({1'b0, ln_dmajor}) >>> 1;
        ln_color     = color;
        ln_busy      = 1'b1;
    endfunction

    // Emit the current pixel and advance the error term by one major step.
    function automatic pixel_t next_pixel();
        pixel_t                p;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        if (!ln_busy)
            return NO_PIXEL;
        px          = ln_steep ? ln_minor : ln_major;
        py          = ln_steep ? ln_major : ln_minor;
        p.x         = px;
        p.y         = py;
        p.color     = ln_color;
        p.valid     = 1'b1;
        p.on_screen = (CFG_BITS'(px) < scr_w) && (CFG_BITS'(py) < scr_h);
        p.last      = ln_major >= ln_major_end;
        if (p.last)
        begin
            ln_busy = 1'b0;
        end
        else
        begin
            ln_err = ln_err - $signed({1'b0, ln_dminor});
            if (ln_err < 0)
            begin
                ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
                ln_err   = ln_err + $signed({1'b0, ln_dmajor});
            end
            ln_major = ln_major + 1'b1;
        end
        return p;
    endfunction

    // Offer one input beat, hold it until taken, then record what it should produce.
    task automatic push_beat(opcode_t op, logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                             logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye,
                             logic [COLOR_BITS-1:0] color, bit typed, pixel_t want);
        pixel_t p;
        while (!steady_mode && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_BITS'({color, ye, xe, ys, xs});
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        if (op == OP_START)
        begin
            load_line(xs, ys, xe, ye, color);
            lines_started++;
        end
        else
        begin
            p = next_pixel();
            pending_pixels.push_back(typed ? want : p);
        end
    endtask

    // Let every expected pixel arrive, then give the pipeline time to settle.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the predictor's copy of the screen size follows it.
    task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = value;
        else
            scr_h = value;
        @(posedge clk);
    endtask

    function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(32)) - 16;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return COORD_BITS'(v);
    endfunction

    // Mostly whole lines with random content; some cut short, some noise beats.
    task automatic draw_random_lines(int budget);
        int                    stop_beats;
        int                    steps;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        stop_beats = beats_sent + budget;
        while (beats_sent < stop_beats)
        begin
            if ($urandom_range(99) < 6)
            begin
                push_beat(opcode_t'($urandom_range(1)), COORD_BITS'($urandom_range(1023)),
                          COORD_BITS'($urandom_range(1023)), COORD_BITS'($urandom_range(1023)),
                          COORD_BITS'($urandom_range(1023)), COLOR_BITS'($urandom_range(65535)),
                          1'b0, NO_PIXEL);
            end
            else
            begin
                xs = COORD_BITS'($urandom_range(1023));
                ys = COORD_BITS'($urandom_range(1023));
                if ($urandom_range(9) < 8)
                begin
                    xe    = near_coord(xs);
                    ye    = near_coord(ys);
                    steps = ($urandom_range(9) == 0) ? int'($urandom_range(8)) : 4096;
                end
                else
                begin
                    xe    = COORD_BITS'($urandom_range(1023));
                    ye    = COORD_BITS'($urandom_range(1023));
                    steps = ($urandom_range(7) == 0) ? 4096 : int'($urandom_range(1, 48));
                end
                push_beat(OP_START, xs, ys, xe, ye, COLOR_BITS'($urandom_range(65535)),
                          1'b0, NO_PIXEL);
                while (ln_busy && steps > 0 && beats_sent < stop_beats)
                begin
                    push_beat(OP_STEP, COORD_BITS'($urandom_range(1023)),
                              COORD_BITS'($urandom_range(1023)),
                              COORD_BITS'($urandom_range(1023)),
                              COORD_BITS'($urandom_range(1023)),
                              COLOR_BITS'($urandom_range(65535)), 1'b0, NO_PIXEL);
                    steps--;
                end
                // Occasionally step past the end of the line.
                if (!ln_busy && $urandom_range(3) == 0)
                    push_beat(OP_STEP, '0, '0, '0, '0, '0, 1'b0, NO_PIXEL);
            end
        end
    endtask

    // Output side: check each taken beat against the oldest expected pixel.
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x         = m_axis_tdata[0 +: COORD_BITS];
                got.y         = m_axis_tdata[COORD_BITS +: COORD_BITS];
                got.color     = m_axis_tdata[2*COORD_BITS +: COLOR_BITS];
                got.valid     = m_axis_tuser[0];
                got.on_screen = m_axis_tuser[1];
                got.last      = m_axis_tlast;
                if (pending_pixels.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected pixel beat x=%0d y=%0d color=%h valid=%b on=%b last=%b",
                             $realtime, got.x, got.y, got.color, got.valid, got.on_screen,
                             got.last);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (want.valid && !want.on_screen)
                        offscreen_pixels++;
                    if (!want.valid)
                        idle_replies++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: expected x=%0d y=%0d color=%h valid=%b on=%b last=%b",
                                 $realtime, want.x, want.y, want.color, want.valid,
                                 want.on_screen, want.last);
                        $display("%0t:   actual x=%0d y=%0d color=%h valid=%b on=%b last=%b",
                                 $realtime, got.x, got.y, got.color, got.valid,
                                 got.on_screen, got.last);
                    end
                end
            end
            m_axis_tready <= steady_mode || ($urandom_range(99) >= 25);
        end
    end

    // Main sequence: reset, directed table, then random lines per screen setting.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        ln_major      = '0;
        ln_minor      = '0;
        ln_major_end  = '0;
        ln_dmajor     = '0;
        ln_dminor     = '0;
        ln_err        = '0;
        ln_down       = 1'b0;
        ln_steep      = 1'b0;
        ln_busy       = 1'b0;
        ln_color      = '0;
        scr_w         = WIDTH_RESET;
        scr_h         = HEIGHT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_beat(directed_rows[i].op, directed_rows[i].xs, directed_rows[i].ys,
                      directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].color,
                      directed_rows[i].typed, directed_rows[i].want);

        foreach (screen_phases[i])
        begin
            drain_pixels();
            write_reg(REG_SCREEN_WIDTH, screen_phases[i].w);
            write_reg(REG_SCREEN_HEIGHT, screen_phases[i].h);
            steady_mode <= screen_phases[i].calm;
            draw_random_lines(RANDOM_BEATS);
        end

        drain_pixels();
        repeat (8) @(posedge clk);
        $display("Sent %0d beats covering %0d lines over %0d screen settings.",
                 beats_sent, lines_started, NUM_PHASES + 1);
        $display("Checked %0d pixel beats: %0d off screen, %0d idle replies.",
                 pixels_checked, offscreen_pixels, idle_replies);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d pixels still expected.", pending_pixels.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
